FILE: src/pvpo_pkg.sv
// Shared types, widths and constants of the perturb-and-observe tracker.
package pvpo_pkg;

	localparam int unsigned VOLT_W  = 15;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned POWER_W = 2 * VOLT_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Seed ratio numerator over 256, and the power floor for stepping up at the limit
	localparam logic [7:0]         SEED_NUM     = 8'd218;
	localparam logic [POWER_W-1:0] MIN_POWER_UP = POWER_W'(120000);
	localparam logic [VOLT_W-1:0]  REF_MAX      = '1;

	// Register reset values
	localparam logic [VOLT_W-1:0] RST_LOW_LIMIT   = '0;
	localparam logic [CNT_W-1:0]  RST_INTERVAL    = CNT_W'(25);
	localparam logic [VOLT_W-1:0] RST_STEP        = VOLT_W'(10);
	localparam logic [VOLT_W-1:0] RST_CURRENT_MIN = '0;
	localparam logic [CNT_W-1:0]  RST_FILTER      = CNT_W'(250);

	typedef enum logic [1:0] {
		ACT_INIT    = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_DISTURB = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_LIMIT   = 3'd0,
		CFG_INTERVAL    = 3'd1,
		CFG_STEP        = 3'd2,
		CFG_CURRENT_MIN = 3'd3,
		CFG_FILTER      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [VOLT_W-1:0] low_voltage_limit;
		logic [CNT_W-1:0]  tick_interval;
		logic [VOLT_W-1:0] voltage_step;
		logic [VOLT_W-1:0] current_min_limit;
		logic [CNT_W-1:0]  disturb_filter;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]   tick_count;
		logic [VOLT_W-1:0]  reference_voltage;
		logic [CNT_W-1:0]   previous_voltage;
		logic [POWER_W-1:0] previous_power;
		logic [CNT_W-1:0]   stall_count;
	} state_t;

	typedef struct packed {
		action_t           action;
		logic [VOLT_W-1:0] pv_voltage;
		logic [VOLT_W-1:0] pv_current;
		logic [VOLT_W-1:0] charge_current;
		logic              pause;
	} item_t;

	typedef struct packed {
		logic [VOLT_W-1:0] voltage_ref;
		logic              evaluated;
		logic              forced_pulldown;
	} res_t;

endpackage

FILE: src/pvpo_sample_if.sv
// Input channel: one measurement word with its action.
interface pvpo_sample_if;
	import pvpo_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [VOLT_W-1:0] pv_voltage;
	logic [VOLT_W-1:0] pv_current;
	logic [VOLT_W-1:0] charge_current;
	logic              pause;

	modport source (
		output valid, action, pv_voltage, pv_current, charge_current, pause,
		input  ready
	);
	modport sink (
		input  valid, action, pv_voltage, pv_current, charge_current, pause,
		output ready
	);
endinterface

FILE: src/pvpo_result_if.sv
// Output channel: one reference word with its status flags.
interface pvpo_result_if;
	import pvpo_pkg::*;

	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] voltage_ref;
	logic              evaluated;
	logic              forced_pulldown;

	modport source (
		output valid, voltage_ref, evaluated, forced_pulldown,
		input  ready
	);
	modport sink (
		input  valid, voltage_ref, evaluated, forced_pulldown,
		output ready
	);
endinterface

FILE: src/pvpo_cfg_if.sv
// Configuration write channel: register index and write data.
interface pvpo_cfg_if;
	import pvpo_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

FILE: src/pvpo_core.sv
// Next-state and result logic of the tracker for one word.
module pvpo_core (
	input  pvpo_pkg::cfg_t   cfg,
	input  pvpo_pkg::state_t state,
	input  pvpo_pkg::item_t  item,
	output pvpo_pkg::state_t state_next,
	output pvpo_pkg::res_t   res
);
	import pvpo_pkg::*;

	logic [VOLT_W+7:0]         seed_prod;
	logic [VOLT_W-1:0]         seed_raw;
	logic [VOLT_W-1:0]         seed_ref;
	logic [POWER_W-1:0]        power;
	logic signed [VOLT_W+2:0]  ref_ext;
	logic signed [VOLT_W+2:0]  step_ext;
	logic signed [VOLT_W+2:0]  next_ref;
	logic [VOLT_W-1:0]         limited_ref;
	logic                      go_up;
	logic                      go_hold;
	logic [CNT_W-1:0]          tick_inc;
	logic [CNT_W-1:0]          volt_plus_step;
	logic                      stall;
	logic [CNT_W-1:0]          stall_new;

	// Seed at 218/256 of the voltage, never below the lower limit
	assign seed_prod = (VOLT_W+8)'(item.pv_voltage) * (VOLT_W+8)'(SEED_NUM);
	assign seed_raw  = seed_prod[VOLT_W+7:8];
	assign seed_ref  = (seed_raw < cfg.low_voltage_limit) ? cfg.low_voltage_limit : seed_raw;

	assign power          = POWER_W'(item.pv_voltage) * POWER_W'(item.pv_current);
	assign tick_inc       = state.tick_count + CNT_W'(1);
	assign volt_plus_step = CNT_W'(item.pv_voltage) + CNT_W'(cfg.voltage_step);

	// Pick the perturbation direction from power and voltage trends
	always_comb begin
		go_up   = 1'b0;
		go_hold = 1'b0;
		if (state.reference_voltage <= cfg.low_voltage_limit) begin
			go_up   = (power >= MIN_POWER_UP);
			go_hold = !go_up;
		end else if (power < state.previous_power) begin
			go_up = (CNT_W'(item.pv_voltage) < state.previous_voltage);
		end else begin
			go_up = !(CNT_W'(item.pv_voltage) <= state.previous_voltage);
		end
	end

	// Step and clamp the reference between the lower limit and full scale
	assign ref_ext  = $signed((VOLT_W+3)'(state.reference_voltage));
	assign step_ext = $signed((VOLT_W+3)'(cfg.voltage_step));
	always_comb begin
		if (go_hold) begin
			next_ref = ref_ext;
		end else if (go_up) begin
			next_ref = ref_ext + step_ext;
		end else begin
			next_ref = ref_ext - step_ext;
		end
		if (next_ref < $signed((VOLT_W+3)'(cfg.low_voltage_limit))) begin
			limited_ref = cfg.low_voltage_limit;
		end else if (next_ref > $signed((VOLT_W+3)'(REF_MAX))) begin
			limited_ref = REF_MAX;
		end else begin
			limited_ref = next_ref[VOLT_W-1:0];
		end
	end

	// Stall detection for the disturb check
	assign stall = (CNT_W'(state.reference_voltage) > volt_plus_step)
		&& (item.charge_current < cfg.current_min_limit);
	assign stall_new = stall ? (state.stall_count + CNT_W'(1)) : '0;

	// Apply the action
	always_comb begin
		state_next          = state;
		res.evaluated       = 1'b0;
		res.forced_pulldown = 1'b0;
		case (item.action)
			ACT_INIT: begin
				state_next.reference_voltage = seed_ref;
				state_next.previous_voltage  = CNT_W'(seed_ref);
				state_next.previous_power    = '0;
			end
			ACT_TICK: begin
				if (item.pause) begin
					state_next.tick_count        = '0;
					state_next.reference_voltage = item.pv_voltage;
					state_next.previous_power    = '0;
					state_next.previous_voltage  = volt_plus_step;
				end else if (tick_inc >= cfg.tick_interval) begin
					state_next.tick_count        = '0;
					state_next.reference_voltage = limited_ref;
					state_next.previous_voltage  = CNT_W'(item.pv_voltage);
					state_next.previous_power    = power;
					res.evaluated                = 1'b1;
				end else begin
					state_next.tick_count = tick_inc;
				end
			end
			ACT_DISTURB: begin
				if (stall_new >= cfg.disturb_filter) begin
					state_next.stall_count       = '0;
					state_next.reference_voltage = seed_ref;
					res.forced_pulldown          = 1'b1;
				end else begin
					state_next.stall_count = stall_new;
				end
			end
			default: begin
				state_next = state;
			end
		endcase
		res.voltage_ref = state_next.reference_voltage;
	end

endmodule

FILE: src/pv_perturb_observe_mppt.sv
// A word accepted into the input register passes on to the result register once that register is free.
// Throughput: one word per cycle, sustained while the result side keeps up.
// The whole update (including the 15x15 power multiply) runs in the one stage between
// the input register and the result register, so consecutive words need no spacing.
// Reset (arst_n low, asynchronous): tracker state cleared, registers to their defaults,
// both channels empty.
module pv_perturb_observe_mppt (
	input  logic           clk,
	input  logic           arst_n,
	pvpo_sample_if.sink    sample,
	pvpo_result_if.source  result,
	pvpo_cfg_if.sink       cfg
);
	import pvpo_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;
	item_t  item_s1;
	logic   valid_s1;
	res_t   res_next;
	res_t   res_q;
	logic   res_valid_q;
	logic   advance;
	logic   take;

	// Move the staged word into the result register when it is free
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;
	assign cfg.ready    = 1'b1;

	pvpo_core u_core (
		.cfg        (cfg_q),
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.res        (res_next)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_voltage_limit <= RST_LOW_LIMIT;
			cfg_q.tick_interval     <= RST_INTERVAL;
			cfg_q.voltage_step      <= RST_STEP;
			cfg_q.current_min_limit <= RST_CURRENT_MIN;
			cfg_q.disturb_filter    <= RST_FILTER;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_LOW_LIMIT:   cfg_q.low_voltage_limit <= cfg.data[VOLT_W-1:0];
				CFG_INTERVAL:    cfg_q.tick_interval     <= cfg.data[CNT_W-1:0];
				CFG_STEP:        cfg_q.voltage_step      <= cfg.data[VOLT_W-1:0];
				CFG_CURRENT_MIN: cfg_q.current_min_limit <= cfg.data[VOLT_W-1:0];
				CFG_FILTER:      cfg_q.disturb_filter    <= cfg.data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action         <= action_t'(sample.action);
			item_s1.pv_voltage     <= sample.pv_voltage;
			item_s1.pv_current     <= sample.pv_current;
			item_s1.charge_current <= sample.charge_current;
			item_s1.pause          <= sample.pause;
		end
	end

	// Tracker state, updated once per word as it leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.voltage_ref     = res_q.voltage_ref;
	assign result.evaluated       = res_q.evaluated;
	assign result.forced_pulldown = res_q.forced_pulldown;

endmodule

FILE: src/pvpo_checker.sv
// Port-level checks of the tracker, bound to the top level.
module pvpo_checker (
	input logic            clk,
	input logic            arst_n,
	pvpo_sample_if.sink    sample,
	pvpo_result_if.source  result
);

	// One word never both evaluates and forces the reference down
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.evaluated && result.forced_pulldown))
		else $error("evaluated and forced_pulldown both set");

	// A word taken while the output is empty leaves the result valid once it has passed both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && !result.valid) |-> ##2 result.valid)
		else $error("result missing two cycles after accepted word");

	// Hold a pending result until it is taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> result.valid)
		else $error("result dropped before taken");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> ($stable(result.voltage_ref)
			&& $stable(result.evaluated) && $stable(result.forced_pulldown)))
		else $error("result word changed while stalled");

endmodule

bind pv_perturb_observe_mppt pvpo_checker u_pvpo_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);

FILE: bench/pvpo_tracker_check.sv
// Tracker checker: watches all three channels, predicts each result word and compares it.
module pvpo_tracker_check (
	input  logic   clk,
	input  logic   arst_n,
	pvpo_sample_if sample,
	pvpo_result_if result,
	pvpo_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);
	import pvpo_pkg::*;

	// Register shadow and tracker state, as the block should hold them
	cfg_t               settings;
	logic [CNT_W-1:0]   trk_ticks;
	logic [VOLT_W-1:0]  trk_ref;
	logic [CNT_W-1:0]   trk_volt;
	logic [POWER_W-1:0] trk_power;
	logic [CNT_W-1:0]   trk_stalls;

	res_t expected_refs[$];
	res_t predicted;
	res_t want;
	item_t seen;
	int err_count = 0;

	// Clamp a candidate reference to the lower limit and to full scale
	function automatic logic [VOLT_W-1:0] bound_ref(input int nxt);
		if (nxt < int'(settings.low_voltage_limit))
			return settings.low_voltage_limit;
		if (nxt > int'(REF_MAX))
			return REF_MAX;
		return VOLT_W'(nxt);
	endfunction

	// Reference seeded at 218/256 of the panel voltage
	function automatic logic [VOLT_W-1:0] seed_ref(input int v);
		return bound_ref((v * int'(SEED_NUM)) >> 8);
	endfunction

	// Advance the tracker by one word and return the reference it leaves
	task automatic advance_tracker(input item_t w, output res_t r);
		int v, cur, chg, stp, ref_v, power, nxt;
		v     = int'(w.pv_voltage);
		cur   = int'(w.pv_current);
		chg   = int'(w.charge_current);
		stp   = int'(settings.voltage_step);
		ref_v = int'(trk_ref);
		r     = '0;
		case (w.action)
			ACT_INIT: begin
				trk_ref   = seed_ref(v);
				trk_volt  = CNT_W'(trk_ref);
				trk_power = '0;
			end
			ACT_TICK: begin
				if (w.pause) begin
					// paused: follow the live voltage and restart the interval
					trk_ticks = '0;
					trk_ref   = w.pv_voltage;
					trk_power = '0;
					trk_volt  = CNT_W'(v + stp);
				end else begin
					trk_ticks = trk_ticks + 1'b1;
					if (trk_ticks >= settings.tick_interval) begin
						power       = v * cur;
						trk_ticks   = '0;
						r.evaluated = 1'b1;
						// at the floor only step up with enough power
						if (trk_ref <= settings.low_voltage_limit)
							nxt = (power >= int'(MIN_POWER_UP)) ? ref_v + stp : ref_v;
						else if (power < int'(trk_power))
							nxt = (v < int'(trk_volt)) ? ref_v + stp : ref_v - stp;
						else
							nxt = (v <= int'(trk_volt)) ? ref_v - stp : ref_v + stp;
						trk_volt  = CNT_W'(v);
						trk_power = POWER_W'(power);
						trk_ref   = bound_ref(nxt);
					end
				end
			end
			ACT_DISTURB: begin
				// count consecutive stalls, force the reference down once filtered
				if (ref_v > v + stp && chg < int'(settings.current_min_limit))
					trk_stalls = trk_stalls + 1'b1;
				else
					trk_stalls = '0;
				if (trk_stalls >= settings.disturb_filter) begin
					trk_stalls        = '0;
					trk_ref           = seed_ref(v);
					r.forced_pulldown = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.voltage_ref = trk_ref;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.low_voltage_limit <= RST_LOW_LIMIT;
			settings.tick_interval     <= RST_INTERVAL;
			settings.voltage_step      <= RST_STEP;
			settings.current_min_limit <= RST_CURRENT_MIN;
			settings.disturb_filter    <= RST_FILTER;
			trk_ticks   <= '0;
			trk_ref     <= '0;
			trk_volt    <= '0;
			trk_power   <= '0;
			trk_stalls  <= '0;
			expected_refs.delete();
			outstanding <= 0;
			mismatches  <= err_count;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_LOW_LIMIT:   settings.low_voltage_limit = cfg.data[VOLT_W-1:0];
					CFG_INTERVAL:    settings.tick_interval     = cfg.data[CNT_W-1:0];
					CFG_STEP:        settings.voltage_step      = cfg.data[VOLT_W-1:0];
					CFG_CURRENT_MIN: settings.current_min_limit = cfg.data[VOLT_W-1:0];
					CFG_FILTER:      settings.disturb_filter    = cfg.data[CNT_W-1:0];
					default: begin
					end
				endcase
			end

			// compare a delivered result word with the oldest prediction
			if (result.valid && result.ready) begin
				if (expected_refs.size() == 0) begin
					$error("result word with nothing pending: voltage_ref %0d",
						result.voltage_ref);
					err_count++;
				end else begin
					want = expected_refs.pop_front();
					if (result.voltage_ref !== want.voltage_ref) begin
						$error("voltage_ref: expected %0d, got %0d",
							want.voltage_ref, result.voltage_ref);
						err_count++;
					end
					if (result.evaluated !== want.evaluated) begin
						$error("evaluated: expected %0d, got %0d",
							want.evaluated, result.evaluated);
						err_count++;
					end
					if (result.forced_pulldown !== want.forced_pulldown) begin
						$error("forced_pulldown: expected %0d, got %0d",
							want.forced_pulldown, result.forced_pulldown);
						err_count++;
					end
				end
			end

			// predict the result of an accepted sample word
			if (sample.valid && sample.ready) begin
				seen.action         = action_t'(sample.action);
				seen.pv_voltage     = sample.pv_voltage;
				seen.pv_current     = sample.pv_current;
				seen.charge_current = sample.charge_current;
				seen.pause          = sample.pause;
				advance_tracker(seen, predicted);
				expected_refs.push_back(predicted);
			end

			outstanding <= expected_refs.size();
			mismatches  <= err_count;
		end
	end

endmodule

FILE: bench/tb.sv
// Top of the tracker bench: clock, reset, stimulus, result-side stalls and the verdict.
module tb;
	import pvpo_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS = 75;

	typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY3} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	int mismatches;
	int outstanding;
	int unsigned cycle_count = 0;

	// Sender burst state and the register values now in force
	int burst_left = 0;
	int curmin_now;
	int filter_now;

	pvpo_sample_if sample_ch();
	pvpo_result_if result_ch();
	pvpo_cfg_if    cfg_ch();

	pv_perturb_observe_mppt dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	pvpo_tracker_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic item_t mk(input action_t a, input int v, input int cur,
			input int chg, input bit p);
		item_t w;
		w.action         = a;
		w.pv_voltage     = VOLT_W'(v);
		w.pv_current     = VOLT_W'(cur);
		w.charge_current = VOLT_W'(chg);
		w.pause          = p;
		return w;
	endfunction

	// Random value around base, kept inside the 15-bit range
	function automatic int near(input int base, input int span);
		int x;
		x = base + int'($urandom_range(0, 2 * span)) - span;
		if (x < 0)
			x = 0;
		if (x > 32767)
			x = 32767;
		return x;
	endfunction

	// Mostly a typical value, sometimes one of the two extremes
	function automatic int choose(input int lo_ext, input int hi_ext, input int lo, input int hi);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return lo_ext;
		if (roll == 1)
			return hi_ext;
		return int'($urandom_range(lo, hi));
	endfunction

	// Offer one word, hold it until taken, then maybe end the burst with a gap
	task automatic offer(input item_t w);
		sample_ch.valid          <= 1'b1;
		sample_ch.action         <= w.action;
		sample_ch.pv_voltage     <= w.pv_voltage;
		sample_ch.pv_current     <= w.pv_current;
		sample_ch.charge_current <= w.charge_current;
		sample_ch.pause          <= w.pause;
		do @(posedge clk); while (!sample_ch.ready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 120 : int'($urandom_range(1, 24));
		end
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write all five registers while the block is idle
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] ivl,
			input logic [CFG_DATA_W-1:0] stp, input logic [CFG_DATA_W-1:0] cmin,
			input logic [CFG_DATA_W-1:0] flt);
		settle();
		curmin_now = int'(cmin[VOLT_W-1:0]);
		filter_now = int'(flt);
		write_reg(CFG_LOW_LIMIT, low);
		write_reg(CFG_INTERVAL, ivl);
		write_reg(CFG_STEP, stp);
		write_reg(CFG_CURRENT_MIN, cmin);
		write_reg(CFG_FILTER, flt);
	endtask

	// Random settings; the 15-bit registers also get a random unused top bit
	task automatic random_settings();
		apply_settings(
			{1'($urandom_range(0, 1)), 15'(choose(0, 32767, 0, 2000))},
			16'(choose(0, 65535, 1, 6)),
			{1'($urandom_range(0, 1)), 15'(choose(0, 32767, 1, 60))},
			{1'($urandom_range(0, 1)), 15'(choose(0, 32767, 100, 5000))},
			16'(choose(0, 65535, 1, 6)));
	endtask

	// Mostly well-formed tracking and stall runs, with some noise between them
	task automatic random_phase(input int words);
		int sent, n, op_v, op_i, chg;
		int unsigned roll;
		sent = 0;
		while (sent < words) begin
			roll = $urandom_range(0, 9);
			if (roll < 5) begin
				// tracking run: seed, then ticks around a drifting operating point
				op_v = int'($urandom_range(200, 32767));
				op_i = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767))
					: int'($urandom_range(0, 400));
				offer(mk(ACT_INIT, near(op_v, 20), op_i, 0, 1'b0));
				sent++;
				n = int'($urandom_range(4, 30));
				repeat (n) begin
					op_v = near(op_v, 25);
					op_i = near(op_i, 10);
					roll = $urandom_range(0, 19);
					if (roll == 0)
						offer(mk(ACT_TICK, near(op_v, 30), near(op_i, 30), 0, 1'b1));
					else if (roll == 1)
						offer(mk(ACT_DISTURB, near(op_v, 30), op_i,
							int'($urandom_range(0, 32767)), 1'b0));
					else
						offer(mk(ACT_TICK, near(op_v, 30), near(op_i, 30),
							int'($urandom_range(0, 32767)), 1'b0));
					sent++;
				end
			end else if (roll < 8) begin
				// stall run: high seed, then low voltage with little charge current
				offer(mk(ACT_INIT, int'($urandom_range(8000, 32767)), 0, 0, 1'b0));
				sent++;
				n = (filter_now <= 8) ? filter_now + int'($urandom_range(0, 4))
					: int'($urandom_range(3, 12));
				repeat (n) begin
					if (curmin_now > 0 && $urandom_range(0, 9) != 0)
						chg = int'($urandom_range(0, curmin_now - 1));
					else
						chg = int'($urandom_range(curmin_now, 32767));
					offer(mk(ACT_DISTURB, int'($urandom_range(0, 4000)),
						int'($urandom_range(0, 32767)), chg, 1'($urandom_range(0, 1))));
					sent++;
				end
			end else begin
				// noise over the whole field ranges
				n = int'($urandom_range(1, 6));
				repeat (n) begin
					offer(mk(action_t'($urandom_range(0, 3)), int'($urandom_range(0, 32767)),
						int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)),
						1'($urandom_range(0, 1))));
					sent++;
				end
			end
		end
	endtask

	// Result side: changing stall patterns plus one long hold-off
	initial begin : result_side
		int taken, mode_left, hold, beat;
		bit pressed;
		rx_mode_t mode;
		taken     = 0;
		mode_left = 0;
		hold      = 0;
		beat      = 0;
		pressed   = 1'b0;
		mode      = RX_OPEN;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			beat++;
			if (result_ch.valid && result_ch.ready)
				taken++;
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else if (!pressed && taken >= 200) begin
				// long hold-off so the block backs up into its input
				pressed = 1'b1;
				hold    = 400;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = int'($urandom_range(16, 96));
				end
				mode_left--;
				case (mode)
					RX_OPEN:   result_ch.ready <= 1'b1;
					RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: result_ch.ready <= ($urandom_range(0, 7) != 0);
					default:   result_ch.ready <= (beat % 3 == 0);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n                   = 1'b0;
		sample_ch.valid          = 1'b0;
		sample_ch.action         = '0;
		sample_ch.pv_voltage     = '0;
		sample_ch.pv_current     = '0;
		sample_ch.charge_current = '0;
		sample_ch.pause          = 1'b0;
		result_ch.ready          = 1'b0;
		cfg_ch.valid             = 1'b0;
		cfg_ch.index             = '0;
		cfg_ch.data              = '0;
		curmin_now               = int'(RST_CURRENT_MIN);
		filter_now               = int'(RST_FILTER);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: seeds at both ends, unknown action, paused tick
		offer(mk(ACT_INIT, 32767, 0, 0, 1'b0));
		offer(mk(ACT_INIT, 0, 32767, 32767, 1'b1));
		offer(mk(action_t'(ACT_NONE), 32767, 32767, 32767, 1'b1));
		offer(mk(ACT_TICK, 32767, 32767, 0, 1'b1));
		offer(mk(ACT_TICK, 1234, 100, 0, 1'b0));
		offer(mk(ACT_DISTURB, 0, 0, 0, 1'b0));
		offer(mk(ACT_INIT, 1000, 0, 0, 1'b0));

		// Zero interval and filter, full-scale step: clamp, saturate, forced pulldown
		apply_settings(16'd0, 16'd0, 16'd32767, 16'd32767, 16'd0);
		offer(mk(ACT_TICK, 100, 32767, 0, 1'b0));
		offer(mk(ACT_TICK, 32767, 32767, 0, 1'b0));
		offer(mk(ACT_TICK, 200, 10, 0, 1'b0));
		offer(mk(ACT_DISTURB, 0, 0, 0, 1'b0));
		offer(mk(ACT_TICK, 10, 10, 0, 1'b0));
		offer(mk(ACT_TICK, 400, 300, 0, 1'b0));
		offer(mk(ACT_TICK, 32767, 0, 0, 1'b1));
		offer(mk(ACT_TICK, 32767, 0, 0, 1'b0));
		offer(mk(ACT_TICK, 300, 300, 0, 1'b0));

		// Top lower limit (with the unused data bit set), zero step, widest interval
		apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
		offer(mk(ACT_INIT, 100, 0, 0, 1'b0));
		offer(mk(ACT_TICK, 5, 0, 0, 1'b1));
		offer(mk(ACT_TICK, 5, 5, 0, 1'b0));
		offer(mk(ACT_DISTURB, 0, 0, 0, 1'b0));
		offer(mk(ACT_INIT, 0, 0, 0, 1'b0));

		// Random phases: a friendly setting first, then random ones
		apply_settings(16'd300, 16'd2, 16'd20, 16'd2000, 16'd3);
		random_phase(PHASE_WORDS);
		for (int ph = 1; ph < RANDOM_PHASES; ph++) begin
			random_settings();
			random_phase(PHASE_WORDS);
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
